>>> rtl/core/pmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared widths, register codes and queue command type for the polynomial
// multiply unit.
// ----------------------------------------------------------------------------
package pmu_pkg;

	localparam int MAX_DEGREE_DEF = 15;
	localparam int IDX_W          = 4;
	localparam int DEG_W          = 4;
	localparam int COEF_W         = 16;
	localparam int PROD_W         = 2 * COEF_W;
	localparam int POW_W          = 5;
	localparam int SUM_W          = 40;
	localparam int CFG_IDX_W      = 2;
	localparam int QUEUE_DEPTH    = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEGREE_A = 2'd0,
		REG_DEGREE_B = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_TRIGGER = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [IDX_W-1:0]          idx;
		logic signed [COEF_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/core/pmu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_front
// Accepts input items, drops out-of-range loads and classifies the rest as
// A load, B load or B load that starts a product.
// ----------------------------------------------------------------------------
module pmu_front import pmu_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF,
	parameter int IW         = $clog2(MAX_DEGREE + 1)
) (
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [IDX_W-1:0]         coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	input  logic [IW-1:0]            eff_db,
	input  q_status_t                q_status,
	output logic                     push,
	output cmd_t                     push_cmd
);

	logic in_range;
	logic is_trig;

	assign in_ready = !q_status.full;
	assign in_range = (IDX_W+1)'(coef_index) <= (IDX_W+1)'(MAX_DEGREE);
	assign is_trig  = func && ((IDX_W+1)'(coef_index) == (IDX_W+1)'(eff_db));
	assign push     = in_valid && in_ready && in_range;

	always_comb begin
		push_cmd.idx   = coef_index;
		push_cmd.value = coef_value;
		if (!func) begin
			push_cmd.kind = CMD_LOAD_A;
		end else if (is_trig) begin
			push_cmd.kind = CMD_TRIGGER;
		end else begin
			push_cmd.kind = CMD_LOAD_B;
		end
	end

endmodule

>>> rtl/core/pmu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module pmu_queue import pmu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t status
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign status.full  = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign status.empty = cnt_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_cmd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/core/pmu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_back
// Coefficient stores and convolution engine: one multiply-accumulate per cycle
// unless stalled, via read, multiply, accumulate stages into an output register.
// ----------------------------------------------------------------------------
module pmu_back import pmu_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF,
	parameter int IW         = $clog2(MAX_DEGREE + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  q_status_t               q_status,
	input  cmd_t                    q_cmd,
	output logic                    q_pop,
	input  logic [IW-1:0]           eff_da,
	input  logic [IW-1:0]           eff_db,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [POW_W-1:0]        power,
	output logic signed [SUM_W-1:0] product_coeff,
	output logic                    last
);

	localparam int DEPTH = MAX_DEGREE + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                   state_q;
	logic [POW_W-1:0]         pow_q;
	logic [IW-1:0]            i_q;
	logic                     first_q;

	logic signed [COEF_W-1:0] a_mem [DEPTH];
	logic signed [COEF_W-1:0] b_mem [DEPTH];

	logic                     vld_s1;
	logic                     first_s1;
	logic                     lastp_s1;
	logic                     last_s1;
	logic [POW_W-1:0]         pow_s1;
	logic signed [COEF_W-1:0] a_s1;
	logic signed [COEF_W-1:0] b_s1;

	logic                     vld_s2;
	logic                     first_s2;
	logic                     lastp_s2;
	logic                     last_s2;
	logic [POW_W-1:0]         pow_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [SUM_W-1:0]  acc_q;
	logic                     out_valid_q;
	logic [POW_W-1:0]         power_q;
	logic signed [SUM_W-1:0]  coeff_q;
	logic                     last_q;

	logic                     adv;
	logic                     issue;
	logic [POW_W-1:0]         top;
	logic [POW_W-1:0]         pow_n;
	logic [IW-1:0]            hi;
	logic [IW-1:0]            lo_n;
	logic [IW-1:0]            j;
	logic                     lastp;
	logic                     lastall;
	logic                     start;
	logic [IW-1:0]            wr_idx;
	logic signed [SUM_W-1:0]  sum;

	assign adv     = !out_valid_q || out_ready;
	assign q_pop   = (state_q == ST_IDLE) && !q_status.empty;
	assign start   = q_pop && (q_cmd.kind == CMD_TRIGGER);
	assign issue   = (state_q == ST_RUN) && adv;
	assign wr_idx  = IW'(q_cmd.idx);
	assign top     = POW_W'(eff_da) + POW_W'(eff_db);
	assign pow_n   = pow_q + 1'b1;
	assign hi      = (pow_q < POW_W'(eff_da)) ? IW'(pow_q) : eff_da;
	assign lo_n    = (pow_n > POW_W'(eff_db)) ? IW'(pow_n - POW_W'(eff_db)) : '0;
	assign j       = IW'(pow_q - POW_W'(i_q));
	assign lastp   = i_q == hi;
	assign lastall = lastp && (pow_q == top);
	assign sum     = first_s2 ? SUM_W'(prod_s2) : acc_q + SUM_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pow_q   <= '0;
			i_q     <= '0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						pow_q   <= '0;
						i_q     <= '0;
						first_q <= 1'b1;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (lastp) begin
							if (lastall) begin
								state_q <= ST_IDLE;
							end
							pow_q   <= pow_n;
							i_q     <= lo_n;
							first_q <= 1'b1;
						end else begin
							i_q     <= i_q + 1'b1;
							first_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// coefficient stores and datapath
	always_ff @(posedge clk) begin
		if (q_pop && (q_cmd.kind == CMD_LOAD_A)) begin
			a_mem[wr_idx] <= q_cmd.value;
		end
		if (q_pop && (q_cmd.kind != CMD_LOAD_A)) begin
			b_mem[wr_idx] <= q_cmd.value;
		end
		if (adv) begin
			a_s1     <= a_mem[i_q];
			b_s1     <= b_mem[j];
			first_s1 <= first_q;
			lastp_s1 <= lastp;
			last_s1  <= lastall;
			pow_s1   <= pow_q;
			prod_s2  <= a_s1 * b_s1;
			first_s2 <= first_s1;
			lastp_s2 <= lastp_s1;
			last_s2  <= last_s1;
			pow_s2   <= pow_s1;
			if (vld_s2) begin
				acc_q <= sum;
				if (lastp_s2) begin
					power_q <= pow_s2;
					coeff_q <= sum;
					last_q  <= last_s2;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= issue;
				vld_s2 <= vld_s1;
			end
			if (adv && vld_s2 && lastp_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign power         = power_q;
	assign product_coeff = coeff_q;
	assign last          = last_q;

endmodule

>>> rtl/core/polynomial_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_multiply_unit
// Integer polynomial product by discrete convolution.
// ----------------------------------------------------------------------------
// Coefficient loads are taken one per cycle, while the queue is not full, into
// a four-entry command queue and written to the A or B store one per cycle
// while no product runs. A B load at power degree_b starts a product: a single
// 16x16 multiplier with a 40-bit accumulator does one term per cycle while the
// output is not stalled, through read, multiply and accumulate stages, and
// emits degree_a+degree_b+1 coefficients from power 0 up, the last one marked.
// Loads keep entering the queue during a product until it fills. Degrees above
// MAX_DEGREE saturate; loads at a power above MAX_DEGREE are dropped.
// ----------------------------------------------------------------------------
module polynomial_multiply_unit import pmu_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [DEG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic [IDX_W-1:0]        coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [POW_W-1:0]        power,
	output logic signed [SUM_W-1:0] product_coeff,
	output logic                    last
);

	localparam int IW = $clog2(MAX_DEGREE + 1);

	logic [DEG_W-1:0] degree_a_q;
	logic [DEG_W-1:0] degree_b_q;
	logic [IW-1:0]    eff_da;
	logic [IW-1:0]    eff_db;
	logic             push;
	cmd_t             push_cmd;
	cmd_t             pop_cmd;
	logic             pop;
	q_status_t        q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_a_q <= '0;
			degree_b_q <= '0;
		end else if (cfg_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEGREE_A: degree_a_q <= cfg_data;
				REG_DEGREE_B: degree_b_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign eff_da = IW'(((DEG_W+1)'(degree_a_q) > (DEG_W+1)'(MAX_DEGREE)) ?
		(DEG_W+1)'(MAX_DEGREE) : (DEG_W+1)'(degree_a_q));
	assign eff_db = IW'(((DEG_W+1)'(degree_b_q) > (DEG_W+1)'(MAX_DEGREE)) ?
		(DEG_W+1)'(MAX_DEGREE) : (DEG_W+1)'(degree_b_q));

	pmu_front #(
		.MAX_DEGREE (MAX_DEGREE),
		.IW         (IW)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.eff_db     (eff_db),
		.q_status   (q_status),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	pmu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (q_status)
	);

	pmu_back #(
		.MAX_DEGREE (MAX_DEGREE),
		.IW         (IW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.q_cmd         (pop_cmd),
		.q_pop         (pop),
		.eff_da        (eff_da),
		.eff_db        (eff_db),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.power         (power),
		.product_coeff (product_coeff),
		.last          (last)
	);

endmodule

>>> rtl/core/pmu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_checker
// Port-level checks on the result stream of the polynomial multiply unit.
// ----------------------------------------------------------------------------
module pmu_checker import pmu_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_en,
	input logic [CFG_IDX_W-1:0]     cfg_index,
	input logic [DEG_W-1:0]         cfg_data,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [POW_W-1:0]         power,
	input logic signed [SUM_W-1:0]  product_coeff,
	input logic                     last
);

	logic [POW_W-1:0] da_q;
	logic [POW_W-1:0] db_q;
	logic [POW_W-1:0] exp_pow_q;
	logic [POW_W-1:0] sat_data;
	logic [POW_W-1:0] top;

	assign sat_data = (POW_W'(cfg_data) > POW_W'(MAX_DEGREE)) ?
		POW_W'(MAX_DEGREE) : POW_W'(cfg_data);
	assign top = da_q + db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			da_q      <= '0;
			db_q      <= '0;
			exp_pow_q <= '0;
		end else begin
			if (cfg_en && (cfg_reg_t'(cfg_index) == REG_DEGREE_A)) begin
				da_q <= sat_data;
			end
			if (cfg_en && (cfg_reg_t'(cfg_index) == REG_DEGREE_B)) begin
				db_q <= sat_data;
			end
			if (out_valid && out_ready) begin
				exp_pow_q <= last ? '0 : power + 1'b1;
			end
		end
	end

	// stalled transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(power) &&
		$stable(product_coeff) && $stable(last))
		else $error("result changed while stalled");

	a_pow_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> power == exp_pow_q)
		else $error("result power out of sequence");

	a_last_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (power == top)))
		else $error("last mark not on the highest power");

endmodule

bind polynomial_multiply_unit pmu_checker #(.MAX_DEGREE(MAX_DEGREE)) u_pmu_checker (.*);
